@@ design/assert_macros.svh @@
// assertion macros used by the shift cell design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ design/stms_pkg.sv @@
// shared types and constants for the scale to multiplier and shift search
package stms_pkg;

    localparam logic [1:0] REG_FIRST_SHIFT = 2'd0;
    localparam logic [1:0] REG_END_SHIFT   = 2'd1;
    localparam logic [1:0] REG_WIDE        = 2'd2;

    localparam logic signed [5:0] FIRST_SHIFT_RESET = -6'sd32;
    localparam logic [4:0]        END_SHIFT_RESET   = 5'd31;

    localparam logic [8:0] EXP_SUBNORMAL = 9'(-149);
    localparam logic [8:0] EXP_BIAS      = 9'd150;

    localparam logic [55:0] LIMIT_NARROW = 56'd127;
    localparam logic [55:0] LIMIT_WIDE   = 56'd2147483647;

    typedef struct packed {
        logic signed [5:0] first_shift;
        logic [4:0]        end_shift;
        logic              wide;
    } stms_cfg_t;

    typedef struct packed {
        logic              special;
        logic              neg;
        logic [23:0]       mant;
        logic signed [8:0] expo;
        logic              have;
        logic [24:0]       best_r;
        logic [31:0]       best_m;
        logic signed [5:0] best_n;
    } stms_item_t;

endpackage

@@ design/stms_cell.sv @@
// one shift candidate: evaluates its shift and keeps the running best
module stms_cell
    import stms_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  stms_cfg_t  cfg,
    input  logic       up_valid,
    output logic       up_stall,
    input  stms_item_t up_item,
    output logic       dn_valid,
    input  logic       dn_stall,
    output stms_item_t dn_item
);

`include "assert_macros.svh"

    logic       valid_reg;
    logic       valid_next;
    stms_item_t item_reg;
    stms_item_t item_next;

    logic signed [7:0] fs_ext;
    logic signed [7:0] end_ext;
    logic signed [7:0] n;
    logic signed [9:0] k;
    logic [9:0]        d;
    logic [4:0]        dd;
    logic [23:0]       mask;
    logic [23:0]       low;
    logic              up;
    logic [55:0]       shifted;
    logic [55:0]       m_c;
    logic [24:0]       r_c;
    logic              fit_ok;
    logic              active;
    logic              take;
    logic [55:0]       limit;

    assign up_stall = valid_reg & dn_stall;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_comb
    begin
        fs_ext  = {{2{cfg.first_shift[5]}}, cfg.first_shift};
        end_ext = {3'b000, cfg.end_shift};
        n       = fs_ext + 8'(INDEX);
        k       = {{1{up_item.expo[8]}}, up_item.expo} + {{2{n[7]}}, n};
        d       = 10'(-k);
        dd      = d[4:0];
        mask    = (24'd1 << dd) - 24'd1;
        low     = up_item.mant & mask;
        up      = (dd != 5'd0) ? up_item.mant[dd - 5'd1] : 1'b0;
        shifted = {32'd0, up_item.mant} << k[4:0];
        limit   = cfg.wide ? LIMIT_WIDE : LIMIT_NARROW;
        active  = !up_item.special && (n < end_ext);

        fit_ok = 1'b1;
        m_c    = '0;
        r_c    = '0;
        if (!k[9])
        begin
            if (k[9:5] != 5'd0)
            begin
                fit_ok = (up_item.mant == 24'd0);
            end
            else
            begin
                m_c = shifted;
            end
        end
        else if (d >= 10'd25)
        begin
            r_c = {1'b0, up_item.mant};
        end
        else
        begin
            m_c = 56'(up_item.mant >> dd) + 56'(up);
            r_c = up ? ((25'd1 << dd) - {1'b0, low}) : {1'b0, low};
        end

        take = active && fit_ok && (m_c < limit)
            && (!up_item.have || (r_c < up_item.best_r));

        item_next = up_item;
        if (take)
        begin
            item_next.have   = 1'b1;
            item_next.best_r = r_c;
            item_next.best_m = m_c[31:0];
            item_next.best_n = n[5:0];
        end

        valid_next = valid_reg;
        if (!up_stall)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
        begin
            item_reg <= item_next;
        end
    end

    `ASSERT_NEXT(a_hold_on_stall, valid_reg && dn_stall, valid_reg && $stable(item_reg))
    `ASSERT_IMPL(a_special_empty, valid_reg && item_reg.special, !item_reg.have)
    `ASSERT_IMPL(a_resid_bound, valid_reg && item_reg.have, item_reg.best_r <= {1'b0, item_reg.mant})

endmodule

@@ design/scale_to_multiplier_shift.sv @@
// top level: float scale to integer multiplier and shift, one cell per shift
//
//  channel   direction  fields                               handshake
//  in        input      scale_bits                           in_valid / in_stall
//  out       output     multiplier, shift_amount, found      out_valid / out_stall
//  cfg       input      cfg_index, cfg_data                  cfg_write
//
// one transfer per cycle in and out unless out_stall holds the chain of cells
// each cell owns one candidate shift and registers the running best
// reset empties every cell and loads the register reset values
// a stall at the output backs up cell by cell; empty cells still fill
module scale_to_multiplier_shift
    import stms_pkg::*;
#(
    parameter int NUM_SHIFTS = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        scale_bits,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] multiplier,
    output logic signed [5:0]  shift_amount,
    output logic               found
);

    stms_cfg_t  cfg_reg;
    stms_cfg_t  cfg_next;
    stms_item_t in_item;
    stms_item_t last_item;

    logic       chain_valid [NUM_SHIFTS + 1];
    logic       chain_stall [NUM_SHIFTS + 1];
    stms_item_t chain_item  [NUM_SHIFTS + 1];

    logic [7:0] expf;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FIRST_SHIFT: cfg_next.first_shift = cfg_data;
                REG_END_SHIFT:   cfg_next.end_shift   = cfg_data[4:0];
                REG_WIDE:        cfg_next.wide        = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_shift <= FIRST_SHIFT_RESET;
            cfg_reg.end_shift   <= END_SHIFT_RESET;
            cfg_reg.wide        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // unpack the float
    always_comb
    begin
        expf            = scale_bits[30:23];
        in_item         = '0;
        in_item.special = (expf == 8'hFF);
        in_item.neg     = scale_bits[31];
        if (expf == 8'd0)
        begin
            in_item.mant = {1'b0, scale_bits[22:0]};
            in_item.expo = EXP_SUBNORMAL;
        end
        else
        begin
            in_item.mant = {1'b1, scale_bits[22:0]};
            in_item.expo = {1'b0, expf} - EXP_BIAS;
        end
    end

    assign chain_valid[0] = in_valid;
    assign chain_item[0]  = in_item;
    assign in_stall       = chain_stall[0];

    for (genvar g = 0; g < NUM_SHIFTS; g++)
    begin : g_cell
        stms_cell #(
            .INDEX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg_reg),
            .up_valid (chain_valid[g]),
            .up_stall (chain_stall[g]),
            .up_item  (chain_item[g]),
            .dn_valid (chain_valid[g + 1]),
            .dn_stall (chain_stall[g + 1]),
            .dn_item  (chain_item[g + 1])
        );
    end

    assign chain_stall[NUM_SHIFTS] = out_stall;
    assign out_valid               = chain_valid[NUM_SHIFTS];
    assign last_item               = chain_item[NUM_SHIFTS];

    always_comb
    begin
        found        = last_item.have;
        multiplier   = '0;
        shift_amount = '0;
        if (last_item.have)
        begin
            multiplier   = last_item.neg ? -last_item.best_m : last_item.best_m;
            shift_amount = last_item.best_n;
        end
    end

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the scale to multiplier and shift search
module testbench;
    import stms_pkg::*;

    localparam int SHIFT_CELLS  = 63;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 85;
    localparam int NUM_SETTINGS = 7;
    localparam int NUM_DIRECTED = 25;

    typedef struct packed {
        logic signed [31:0] mult;
        logic signed [5:0]  shift;
        logic               found;
    } quant_t;

    typedef struct packed {
        logic [31:0]        bits;
        logic               known;
        logic signed [31:0] mult;
        logic signed [5:0]  shift;
        logic               found;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [5:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        scale_bits;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] multiplier;
    logic signed [5:0]  shift_amount;
    logic               found;

    logic signed [5:0]  first_shift_reg;
    logic [4:0]         end_shift_reg;
    logic               wide_reg;

    quant_t             pending_q [$];
    quant_t             oldest;
    int                 fail_count;
    int                 checked_count;
    int                 found_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 setting_count;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{32'h0000_0000, 1'b1, 32'sd0, -6'sd32, 1'b1},
        '{32'h8000_0000, 1'b1, 32'sd0, -6'sd32, 1'b1},
        '{32'h7f80_0000, 1'b1, 32'sd0, 6'sd0, 1'b0},
        '{32'hff80_0000, 1'b1, 32'sd0, 6'sd0, 1'b0},
        '{32'h7fc0_0000, 1'b1, 32'sd0, 6'sd0, 1'b0},
        '{32'h7f80_0001, 1'b1, 32'sd0, 6'sd0, 1'b0},
        '{32'hffff_ffff, 1'b1, 32'sd0, 6'sd0, 1'b0},
        '{32'h7f7f_ffff, 1'b1, 32'sd0, 6'sd0, 1'b0},
        '{32'hff7f_ffff, 1'b1, 32'sd0, 6'sd0, 1'b0},
        '{32'h0000_0001, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h8000_0001, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h007f_ffff, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h0080_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h3f80_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'hbf80_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h42fe_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'hc2fc_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h3fc0_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'hbec0_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h3eff_ffff, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h4f00_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'hcf00_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h5f00_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h2f80_0000, 1'b0, 32'sd0, 6'sd0, 1'b0},
        '{32'h3f7f_ffff, 1'b0, 32'sd0, 6'sd0, 1'b0}
    };

    scale_to_multiplier_shift #(
        .NUM_SHIFTS (SHIFT_CELLS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .scale_bits   (scale_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .multiplier   (multiplier),
        .shift_amount (shift_amount),
        .found        (found)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic quant_t quantize_scale(input logic [31:0] bits);
        quant_t      res;
        logic [7:0]  expf;
        logic [63:0] mant;
        logic [63:0] limit;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] back;
        logic [63:0] best_r;
        logic [63:0] best_m;
        int          e;
        int          n;
        int          k;
        int          d;
        int          i;
        int          best_n;
        bit          have;
        res = '0;
        expf = bits[30:23];
        limit = wide_reg ? 64'd2147483647 : 64'd127;
        if (expf == 8'hff)
            return res;
        if (expf == 8'h00)
        begin
            mant = {41'd0, bits[22:0]};
            e = -149;
        end
        else
        begin
            mant = {40'd0, 1'b1, bits[22:0]};
            e = int'(expf) - 150;
        end
        have = 1'b0;
        best_r = '0;
        best_m = '0;
        best_n = 0;
        for (i = 0; i < SHIFT_CELLS; i++)
        begin
            n = int'(first_shift_reg) + i;
            if (n >= int'(end_shift_reg))
                break;
            k = e + n;
            if (k >= 0)
            begin
                if (k > 31)
                begin
                    if (mant != 0)
                        continue;
                    m = '0;
                end
                else
                    m = mant << k;
                r = '0;
            end
            else
            begin
                d = -k;
                if (d >= 25)
                begin
                    m = '0;
                    r = mant;
                end
                else
                begin
                    m = (mant + (64'd1 << (d - 1))) >> d;
                    back = m << d;
                    r = (back >= mant) ? back - mant : mant - back;
                end
            end
            if (m >= limit)
                continue;
            if (!have || r < best_r)
            begin
                have = 1'b1;
                best_r = r;
                best_m = m;
                best_n = n;
            end
        end
        if (have)
        begin
            res.mult = bits[31] ? 32'(64'd0 - best_m) : best_m[31:0];
            res.shift = 6'(best_n);
            res.found = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [31:0] random_scale();
        int          sel;
        logic        sgn;
        logic [7:0]  expf;
        logic [22:0] frac;
        sel = $urandom_range(99);
        sgn = 1'($urandom);
        frac = 23'($urandom);
        if (sel < 10)
            return $urandom;
        if (sel < 20)
        begin
            case ($urandom_range(2))
                0: expf = 8'hff;
                1: expf = 8'h00;
                default:
                begin
                    expf = 8'h00;
                    frac = '0;
                end
            endcase
        end
        else if (sel < 35)
        begin
            // low mantissa bits cleared, to land on exact values and rounding ties
            expf = 8'($urandom_range(160, 100));
            frac = frac & (23'h7fffff << $urandom_range(22, 0));
        end
        else if (sel < 45)
            expf = $urandom_range(1) ? 8'($urandom_range(30, 1)) : 8'($urandom_range(254, 200));
        else
            expf = 8'($urandom_range(190, 96));
        return {sgn, expf, frac};
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_FIRST_SHIFT: first_shift_reg = val;
            REG_END_SHIFT:   end_shift_reg = val[4:0];
            REG_WIDE:        wide_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic signed [5:0] first, input logic [4:0] last,
                                 input logic wide);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_FIRST_SHIFT, first);
        write_reg(REG_END_SHIFT, {1'b0, last});
        write_reg(REG_WIDE, {5'd0, wide});
        @(negedge clk);
        cfg_write <= 1'b0;
        setting_count++;
    endtask

    task automatic send_scale(input logic [31:0] bits, input logic known, input quant_t known_res);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        scale_bits <= bits;
        do
            @(posedge clk);
        while (in_stall);
        pending_q.push_back(known ? known_res : quantize_scale(bits));
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected transfer: multiplier %0d shift %0d found %0b",
                       multiplier, shift_amount, found);
                fail_count++;
            end
            else
            begin
                oldest = pending_q.pop_front();
                checked_count++;
                if (found)
                    found_count++;
                if (multiplier !== oldest.mult)
                begin
                    $error("multiplier: expected %0d, got %0d", oldest.mult, multiplier);
                    fail_count++;
                end
                if (shift_amount !== oldest.shift)
                begin
                    $error("shift_amount: expected %0d, got %0d", oldest.shift, shift_amount);
                    fail_count++;
                end
                if (found !== oldest.found)
                begin
                    $error("found: expected %0b, got %0b", oldest.found, found);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        quant_t typed;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_FIRST_SHIFT;
        cfg_data = '0;
        in_valid = 1'b0;
        scale_bits = '0;
        fail_count = 0;
        checked_count = 0;
        found_count = 0;
        setting_count = 1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        first_shift_reg = FIRST_SHIFT_RESET;
        end_shift_reg = END_SHIFT_RESET;
        wide_reg = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows under the reset register values
        send_idle_pct = 27;
        recv_stall_pct = 48;
        foreach (directed_rows[j])
        begin
            typed = '{directed_rows[j].mult, directed_rows[j].shift, directed_rows[j].found};
            send_scale(directed_rows[j].bits, directed_rows[j].known, typed);
        end
        end_burst();

        for (int mode = 0; mode < 3; mode++)
        begin
            for (int p = 0; p < NUM_SETTINGS; p++)
            begin
                case (p)
                    0: apply_setting(-6'sd32, 5'd31, 1'b1);
                    1: apply_setting(6'sd0, 5'd31, 1'b0);
                    2: apply_setting(-6'sd32, 5'd1, 1'b0);
                    3: apply_setting(6'sd0, 5'd1, 1'b1);
                    4: apply_setting(6'sd0, 5'd0, 1'($urandom));
                    default: apply_setting(6'(-int'($urandom_range(32))),
                                           5'($urandom_range(31, 1)), 1'($urandom));
                endcase
                send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 48 : 0;
                recv_stall_pct = (mode == 0) ? 48 : (mode == 1) ? 27 : 0;
                repeat (PHASE_ITEMS)
                    send_scale(random_scale(), 1'b0, '0);
                end_burst();
            end
        end

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d scale transfers (%0d with a fitting shift) over %0d register settings",
                 checked_count, found_count, setting_count);
        $display("idle patterns: sender-heavy, receiver-heavy and back-to-back");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/stms_pkg.sv
design/stms_cell.sv
design/scale_to_multiplier_shift.sv
bench/testbench.sv
